// File: src/surx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// surx_pkg
// Shared types and constants of the sampled serial receiver.
// ----------------------------------------------------------------------------
package surx_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 17;
    localparam int TIME_W   = 32;
    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int FBITS_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_OFFSET    = 2'd3;

    // reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST      = 16'd4;
    localparam logic [PERIOD_W-1:0] HALF_BIT_PERIOD_RST = 16'd2;
    localparam logic [FBITS_W-1:0]  FRAME_BITS_RST      = 6'd9;
    localparam logic [SAMPLE_W-1:0] INPUT_OFFSET_RST    = 16'd0;

    typedef enum logic [2:0] {
        PHASE_IDLE = 3'b001,
        PHASE_DATA = 3'b010,
        PHASE_STOP = 3'b100
    } phase_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]        bit_period;
        logic [PERIOD_W-1:0]        half_bit_period;
        logic [FBITS_W-1:0]         frame_bits;
        logic signed [SAMPLE_W-1:0] input_offset;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              frame_error;
        logic [TIME_W-1:0] elapsed_time;
    } result_t;

endpackage
`default_nettype wire

// File: src/surx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// surx_sample_if / surx_result_if
// Valid/ready channels for input samples and received frames.
// ----------------------------------------------------------------------------
interface surx_sample_if import surx_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface surx_result_if import surx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_word;
    logic              frame_error;
    logic [TIME_W-1:0] elapsed_time;

    modport source (output valid, output data_word, output frame_error,
                    output elapsed_time, input ready);
    modport sink   (input valid, input data_word, input frame_error,
                    input elapsed_time, output ready);
endinterface
`default_nettype wire

// File: src/surx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// surx_core
// Frame receiver state: sample counter, edge detect, bit reads, stop check.
// ----------------------------------------------------------------------------
module surx_core import surx_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire cfg_t                       cfg,
    output logic                            emit,
    output result_t                         result
);

    logic [TIME_W-1:0]     cnt_reg,   cnt_next;   // holds the current sample's count
    logic [TIME_W-1:0]     nrt_reg,   nrt_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     span_reg,  span_next;
    logic                  prev_pos_reg;
    phase_t                phase_reg, phase_next;
    logic [FBITS_W-1:0]    bidx_reg,  bidx_next;
    logic [WORD_WIDTH-1:0] mask_reg,  mask_next;
    logic [WORD_WIDTH-1:0] word_reg,  word_next;

    logic signed [LEVEL_W-1:0] level;
    logic                      lvl_pos;
    logic                      lvl_nonneg;
    logic                      falling;
    logic                      due;
    logic [FBITS_W-1:0]        bidx_inc;

    assign level      = LEVEL_W'(sample) + LEVEL_W'(cfg.input_offset);
    assign lvl_nonneg = ~level[LEVEL_W-1];
    assign lvl_pos    = lvl_nonneg && (level != '0);
    assign falling    = ~lvl_pos && prev_pos_reg;
    assign due        = cnt_reg >= nrt_reg;
    assign bidx_inc   = bidx_reg + FBITS_W'(1);

    always_comb
    begin
        cnt_next   = cnt_reg + TIME_W'(1);
        nrt_next   = nrt_reg;
        start_next = start_reg;
        span_next  = span_reg;
        phase_next = phase_reg;
        bidx_next  = bidx_reg;
        mask_next  = mask_reg;
        word_next  = word_reg;
        emit       = 1'b0;

        case (phase_reg)
            PHASE_STOP:
            begin
                if (due)
                begin
                    emit       = 1'b1;
                    phase_next = PHASE_IDLE;
                    bidx_next  = '0;
                    mask_next  = WORD_WIDTH'(1);
                    word_next  = '0;
                    span_next  = '0;
                end
            end
            PHASE_DATA:
            begin
                if (due)
                begin
                    if (bidx_reg == '0)
                    begin
                        // start bit check
                        if (!lvl_pos)
                        begin
                            bidx_next = FBITS_W'(1);
                            mask_next = WORD_WIDTH'(1);
                            word_next = '0;
                            nrt_next  = nrt_reg + TIME_W'(cfg.bit_period);
                        end
                        else
                        begin
                            phase_next = PHASE_IDLE;
                            bidx_next  = '0;
                            nrt_next   = '0;
                        end
                    end
                    else
                    begin
                        if (lvl_nonneg)
                            word_next = word_reg | mask_reg;
                        mask_next = mask_reg << 1;
                        nrt_next  = nrt_reg + TIME_W'(cfg.bit_period);
                        bidx_next = bidx_inc;
                        if (bidx_inc >= cfg.frame_bits)
                        begin
                            phase_next = PHASE_STOP;
                            bidx_next  = '0;
                        end
                    end
                end
            end
            default:
            begin
                if (falling)
                begin
                    phase_next = PHASE_DATA;
                    start_next = cnt_reg;
                    nrt_next   = cnt_reg + TIME_W'(cfg.half_bit_period);
                    bidx_next  = '0;
                end
            end
        endcase

        // every falling crossing refreshes the span, after any frame end
        if (falling)
            span_next = cnt_reg - start_next;
    end

    assign result.data_word    = DATA_W'(word_reg);
    assign result.frame_error  = ~lvl_pos;
    assign result.elapsed_time = span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= TIME_W'(1);
            nrt_reg      <= '0;
            start_reg    <= '0;
            span_reg     <= '0;
            prev_pos_reg <= 1'b0;
            phase_reg    <= PHASE_IDLE;
            bidx_reg     <= '0;
            mask_reg     <= WORD_WIDTH'(1);
            word_reg     <= '0;
        end
        else if (fire)
        begin
            cnt_reg      <= cnt_next;
            nrt_reg      <= nrt_next;
            start_reg    <= start_next;
            span_reg     <= span_next;
            prev_pos_reg <= lvl_pos;
            phase_reg    <= phase_next;
            bidx_reg     <= bidx_next;
            mask_reg     <= mask_next;
            word_reg     <= word_next;
        end
    end

endmodule
`default_nettype wire

// File: src/sampled_uart_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sampled_uart_receiver
// Serial frame receiver that decodes a level-coded bit stream from audio samples.
// ----------------------------------------------------------------------------
// Takes one sample transaction per clock while the skid stage is empty, and returns
// one frame transaction per received frame. The sample that reads the stop bit sits
// in the input register; the frame state update on it loads the output register, or
// the skid stage while the output is held. The per-sample state update is a single
// registered pass, so the sustained rate is one sample per cycle while the skid
// stage is empty; it holds one finished frame, and samples stall while it is full.
// Configuration writes take effect on the next sample and are meant for idle periods.
module sampled_uart_receiver import surx_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    surx_sample_if.sink               samples,
    surx_result_if.source             results,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_DAT_W-1:0] wr_data
);

    cfg_t                       cfg_reg;
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    result_t                    out_reg;
    logic                       skid_valid_reg;
    result_t                    skid_reg;

    logic    fire;
    logic    emit;
    result_t res;
    logic    res_valid;
    logic    out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period      <= BIT_PERIOD_RST;
            cfg_reg.half_bit_period <= HALF_BIT_PERIOD_RST;
            cfg_reg.frame_bits      <= FRAME_BITS_RST;
            cfg_reg.input_offset    <= INPUT_OFFSET_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BIT_PERIOD:      cfg_reg.bit_period      <= wr_data;
                REG_HALF_BIT_PERIOD: cfg_reg.half_bit_period <= wr_data;
                REG_FRAME_BITS:      cfg_reg.frame_bits      <= wr_data[FBITS_W-1:0];
                REG_INPUT_OFFSET:    cfg_reg.input_offset    <= wr_data;
                default:             ;
            endcase
        end
    end

    // the core only runs when the skid stage has room for a frame
    assign fire          = in_valid_reg && !skid_valid_reg;
    assign samples.ready = !in_valid_reg || fire;
    assign res_valid     = fire && emit;
    assign out_free      = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (samples.ready)
            in_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            sample_reg <= samples.sample;
    end

    surx_core #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .emit   (emit),
        .result (res)
    );

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (res_valid)
            skid_reg <= res;
    end

    assign results.valid        = out_valid_reg;
    assign results.data_word    = out_reg.data_word;
    assign results.frame_error  = out_reg.frame_error;
    assign results.elapsed_time = out_reg.elapsed_time;

endmodule
`default_nettype wire
